// ===== design/grl_pkg.sv =====
// Shared constants, register codes and stage types for the gradient ramp lookup.
`timescale 1ns / 1ps

package grl_pkg;

  // Stop registers and the ceiling on stops in use
  localparam int STOP_REGS  = 4;
  localparam int MAX_STOPS  = 4;
  localparam int STOP_LIMIT = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 3;
  localparam int IDX_W    = 2;
  localparam int POS_W    = 17;
  localparam int COLOR_W  = 32;
  localparam int CHAN_W   = 8;
  localparam int STOP_W   = POS_W + COLOR_W;
  localparam int CFG_IDX_W = 3;
  localparam int LANES    = COLOR_W / CHAN_W;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(65536);

  // Channel divider: dividend 2*num+span, divisor 2*span
  localparam int CH_QW = CHAN_W;
  localparam int CH_DW = POS_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THREE = 3'd6;

  // How t comes out of normalization
  localparam logic [1:0] TK_ZERO = 2'd0;
  localparam logic [1:0] TK_ONE  = 2'd1;
  localparam logic [1:0] TK_DIV  = 2'd2;

  // Segment select result handed to the blend stage
  typedef struct packed {
    logic               direct;
    logic               color_valid;
    logic [COLOR_W-1:0] direct_color;
    logic [COLOR_W-1:0] lo_color;
    logic [COLOR_W-1:0] hi_color;
    logic [POS_W-1:0]   d;
    logic [POS_W-1:0]   span;
  } sel_t;

endpackage

// ===== design/gradient_color_ramp_lookup_unit.sv =====
// Throughput: one sample per cycle; the 16-stage position divider and the
// 8-stage channel divider are fully pipelined, and a stall freezes every stage.
// Reset: synchronous, clears all stage valid bits and loads the register reset
// values (no stops, range 0..65535, stops zero).
`timescale 1ns / 1ps

module gradient_color_ramp_lookup_unit import grl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  sample_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    red_out,
  output logic [CHAN_W-1:0]    green_out,
  output logic [CHAN_W-1:0]    blue_out,
  output logic [CHAN_W-1:0]    alpha_out,
  output logic                 color_valid,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STOP_W-1:0]    cfg_data
);

  logic                             advance;
  logic [CNT_W-1:0]                 stop_count;
  logic [SAMPLE_W-1:0]              range_low;
  logic [SAMPLE_W-1:0]              range_high;
  logic [STOP_REGS-1:0][STOP_W-1:0] stops;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
      range_low  <= '0;
      range_high <= '1;
      stops      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STOP_COUNT: stop_count <= cfg_data[CNT_W-1:0];
        REG_RANGE_LOW:  range_low  <= cfg_data[SAMPLE_W-1:0];
        REG_RANGE_HIGH: range_high <= cfg_data[SAMPLE_W-1:0];
        REG_STOP_ZERO:  stops[0]   <= cfg_data;
        REG_STOP_ONE:   stops[1]   <= cfg_data;
        REG_STOP_TWO:   stops[2]   <= cfg_data;
        REG_STOP_THREE: stops[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sample <= sample_value;
    end
  end

  // Normalization: t = (s - low) * 65536 / (high - low), clamped to 0 at or below low and 65536 at or above high
  logic [1:0]                       tkind;
  logic [SAMPLE_W-1:0]              s1_diff;
  logic [0:0][2*SAMPLE_W-1:0]       t_dividend;
  logic [0:0][SAMPLE_W-1:0]         t_divisor;
  logic                             tq_valid;
  logic [0:0][SAMPLE_W-1:0]         tq;
  logic [1:0]                       tq_kind;
  logic [POS_W-1:0]                 t;

  assign s1_diff = s1_sample - range_low;

  always_comb begin
    if (s1_sample <= range_low) begin
      tkind = TK_ZERO;
    end else if (s1_sample >= range_high) begin
      tkind = TK_ONE;
    end else begin
      tkind = TK_DIV;
    end
    if (tkind == TK_DIV) begin
      t_dividend[0] = {s1_diff, {SAMPLE_W{1'b0}}};
      t_divisor[0]  = range_high - range_low;
    end else begin
      t_dividend[0] = '0;
      t_divisor[0]  = SAMPLE_W'(1);
    end
  end

  grl_div #(
    .QW (SAMPLE_W),
    .DW (SAMPLE_W),
    .NL (1),
    .SW (2)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s1_valid),
    .dividend  (t_dividend),
    .divisor   (t_divisor),
    .in_side   (tkind),
    .out_valid (tq_valid),
    .quotient  (tq),
    .out_side  (tq_kind)
  );

  always_comb begin
    case (tq_kind)
      TK_ZERO: t = '0;
      TK_ONE:  t = POS_ONE;
      TK_DIV:  t = {1'b0, tq[0]};
      default: t = '0;
    endcase
  end

  logic sel_valid;
  sel_t sel;

  grl_select u_select (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_valid    (tq_valid),
    .t           (t),
    .stop_count  (stop_count),
    .range_empty (range_high <= range_low),
    .stops       (stops),
    .out_valid   (sel_valid),
    .sel         (sel)
  );

  // Blend numerators: each channel is round((lo*(span-d) + hi*d) / span)
  localparam int CH_NW = CH_QW + CH_DW;

  logic                            s4_valid;
  logic [LANES-1:0][CH_NW-1:0]     s4_dividend;
  logic [LANES-1:0][CH_DW-1:0]     s4_divisor;
  logic [COLOR_W+1:0]              s4_side;
  logic [LANES-1:0][CH_NW-1:0]     dividend_next;
  logic [LANES-1:0][CH_DW-1:0]     divisor_next;

  always_comb begin
    logic [POS_W-1:0]         rest;
    logic [CHAN_W+POS_W-1:0]  plo;
    logic [CHAN_W+POS_W-1:0]  phi;
    logic [CHAN_W+POS_W-1:0]  num;
    rest = sel.span - sel.d;
    for (int c = 0; c < LANES; c++) begin
      plo = sel.lo_color[CHAN_W*(LANES-1-c) +: CHAN_W] * rest;
      phi = sel.hi_color[CHAN_W*(LANES-1-c) +: CHAN_W] * sel.d;
      num = plo + phi;
      if (sel.direct) begin
        dividend_next[c] = '0;
        divisor_next[c]  = CH_DW'(1);
      end else begin
        dividend_next[c] = CH_NW'({num, 1'b0}) + CH_NW'(sel.span);
        divisor_next[c]  = {sel.span, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_dividend <= dividend_next;
      s4_divisor  <= divisor_next;
      s4_side     <= {sel.direct, sel.color_valid, sel.direct_color};
    end
  end

  logic                        cq_valid;
  logic [LANES-1:0][CH_QW-1:0] cq;
  logic [COLOR_W+1:0]          cq_side;

  grl_div #(
    .QW (CH_QW),
    .DW (CH_DW),
    .NL (LANES),
    .SW (COLOR_W + 2)
  ) u_cdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s4_valid),
    .dividend  (s4_dividend),
    .divisor   (s4_divisor),
    .in_side   (s4_side),
    .out_valid (cq_valid),
    .quotient  (cq),
    .out_side  (cq_side)
  );

  // Output register
  logic               cq_direct;
  logic [COLOR_W-1:0] cq_color;

  assign cq_direct = cq_side[COLOR_W+1];
  assign cq_color  = cq_side[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      color_valid <= cq_side[COLOR_W];
      red_out     <= cq_direct ? cq_color[31:24] : cq[0];
      green_out   <= cq_direct ? cq_color[23:16] : cq[1];
      blue_out    <= cq_direct ? cq_color[15:8]  : cq[2];
      alpha_out   <= cq_direct ? cq_color[7:0]   : cq[3];
    end
  end

endmodule

// ===== design/grl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
`timescale 1ns / 1ps

module grl_div import grl_pkg::*; #(
  parameter int QW  = 8,
  parameter int DW  = 18,
  parameter int NL  = 1,
  parameter int SW  = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [NL-1:0][QW+DW-1:0]  dividend,
  input  logic [NL-1:0][DW-1:0]     divisor,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [NL-1:0][QW-1:0]     quotient,
  output logic [SW-1:0]             out_side
);

  // Caller guarantees dividend >> QW is below the divisor.
  logic [QW-1:0]              vld;
  logic [SW-1:0]              side [QW];
  logic [NL-1:0][DW-1:0]      rem  [QW];
  logic [NL-1:0][QW-1:0]      low  [QW];
  logic [NL-1:0][QW-1:0]      quo  [QW];
  logic [NL-1:0][DW-1:0]      dvs  [QW];

  genvar k, l;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic                  pv;
      logic [SW-1:0]         pside;
      logic [NL-1:0][DW-1:0] prem;
      logic [NL-1:0][QW-1:0] plow;
      logic [NL-1:0][QW-1:0] pquo;
      logic [NL-1:0][DW-1:0] pdvs;
      logic [NL-1:0][DW-1:0] rem_next;
      logic [NL-1:0][QW-1:0] low_next;
      logic [NL-1:0][QW-1:0] quo_next;

      if (k == 0) begin : g_first
        assign pv    = in_valid;
        assign pside = in_side;
        assign pdvs  = divisor;
        assign pquo  = '0;
        for (l = 0; l < NL; l++) begin : g_split
          assign prem[l] = dividend[l][QW+DW-1:QW];
          assign plow[l] = dividend[l][QW-1:0];
        end
      end else begin : g_rest
        assign pv    = vld[k-1];
        assign pside = side[k-1];
        assign prem  = rem[k-1];
        assign plow  = low[k-1];
        assign pquo  = quo[k-1];
        assign pdvs  = dvs[k-1];
      end

      for (l = 0; l < NL; l++) begin : g_lane
        logic [DW:0] cand;
        logic [DW:0] diffv;
        logic        ge;
        assign cand  = {prem[l], plow[l][QW-1]};
        assign ge    = cand >= {1'b0, pdvs[l]};
        assign diffv = cand - {1'b0, pdvs[l]};
        assign rem_next[l] = ge ? diffv[DW-1:0] : cand[DW-1:0];
        assign low_next[l] = {plow[l][QW-2:0], 1'b0};
        assign quo_next[l] = {pquo[l][QW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (en) begin
          vld[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= pside;
          rem[k]  <= rem_next;
          low[k]  <= low_next;
          quo[k]  <= quo_next;
          dvs[k]  <= pdvs;
        end
      end
    end
  endgenerate

  assign out_valid = vld[QW-1];
  assign quotient  = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

// ===== design/grl_select.sv =====
// Segment search: picks the stop pair around t, or a stop colour outright.
`timescale 1ns / 1ps

module grl_select import grl_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [POS_W-1:0]                  t,
  input  logic [CNT_W-1:0]                  stop_count,
  input  logic                              range_empty,
  input  logic [STOP_REGS-1:0][STOP_W-1:0]  stops,
  output logic                              out_valid,
  output sel_t                              sel
);

  logic [POS_W-1:0]   pos   [STOP_REGS];
  logic [COLOR_W-1:0] color [STOP_REGS];
  logic [CNT_W-1:0]   n_eff;
  logic [IDX_W-1:0]   last;
  sel_t               sel_next;

  always_comb begin
    for (int k = 0; k < STOP_REGS; k++) begin
      pos[k]   = (stops[k][STOP_W-1:COLOR_W] > POS_ONE) ? POS_ONE
                                                        : stops[k][STOP_W-1:COLOR_W];
      color[k] = stops[k][COLOR_W-1:0];
    end
  end

  assign n_eff = (stop_count > CNT_W'(STOP_LIMIT)) ? CNT_W'(STOP_LIMIT) : stop_count;
  assign last  = IDX_W'(n_eff - CNT_W'(1));

  always_comb begin
    logic found;
    found                 = 1'b0;
    sel_next.direct       = 1'b1;
    sel_next.color_valid  = 1'b1;
    sel_next.direct_color = color[0];
    sel_next.lo_color     = '0;
    sel_next.hi_color     = '0;
    sel_next.d            = '0;
    sel_next.span         = '0;
    if (n_eff == '0) begin
      sel_next.color_valid  = 1'b0;
      sel_next.direct_color = '0;
    end else if (range_empty || t <= pos[0]) begin
      sel_next.direct_color = color[0];
    end else if (t >= pos[last]) begin
      sel_next.direct_color = color[last];
    end else begin
      // first stop at or above t; a stop not above its predecessor gives its own colour, no match gives the last colour
      sel_next.direct_color = color[last];
      for (int i = 1; i < STOP_REGS; i++) begin
        if (!found && CNT_W'(i) < n_eff && t <= pos[i]) begin
          found = 1'b1;
          if (pos[i] <= pos[i-1]) begin
            sel_next.direct_color = color[i];
          end else begin
            sel_next.direct   = 1'b0;
            sel_next.lo_color = color[i-1];
            sel_next.hi_color = color[i];
            sel_next.d        = t - pos[i-1];
            sel_next.span     = pos[i] - pos[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel <= sel_next;
    end
  end

endmodule
